### src/i2cmu_pkg.sv
// ----------------------------------------------------------------------------
// i2cmu_pkg
// types, register map and bit definitions of the i2c master unit register model
// ----------------------------------------------------------------------------
package i2cmu_pkg;

  // packed widths of the stream payloads
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 48;

  // register window, aligned word index (offset bits 4:2)
  typedef enum logic [2:0] {
    RegControl  = 3'd0,
    RegStatus   = 3'd1,
    RegSlvAddr  = 3'd2,
    RegDataBuf  = 3'd3,
    RegHole     = 3'd4,
    RegBusMon   = 3'd5,
    RegBusCtrl  = 3'd6,
    RegHoleTop  = 3'd7
  } i2cmu_reg_e;

  typedef enum logic [1:0] {
    SizeByte = 2'd0,
    SizeHalf = 2'd1,
    SizeWord = 2'd2,
    SizeRsvd = 2'd3
  } i2cmu_size_e;

  typedef enum logic [1:0] {
    CmdNone  = 2'd0,
    CmdAddr  = 2'd1,
    CmdWrite = 2'd2,
    CmdRead  = 2'd3
  } i2cmu_cmd_e;

  typedef enum logic {
    OpRead  = 1'b0,
    OpWrite = 1'b1
  } i2cmu_op_e;

  // control register bits
  localparam logic [15:0] CrReset  = 16'h4000;
  localparam logic [15:0] CrAldIe  = 16'h1000;
  localparam logic [15:0] CrSsdIe  = 16'h0800;
  localparam logic [15:0] CrBerrIe = 16'h0400;
  localparam logic [15:0] CrRxfIe  = 16'h0200;
  localparam logic [15:0] CrTxeIe  = 16'h0100;
  localparam logic [15:0] CrAbort  = 16'h0010;
  localparam logic [15:0] CrTbyte  = 16'h0008;
  localparam logic [15:0] CrStop   = 16'h0002;
  localparam logic [15:0] CrStart  = 16'h0001;

  // status register bits
  localparam logic [10:0] SrBerr    = 11'h400;
  localparam logic [10:0] SrRxFull  = 11'h080;
  localparam logic [10:0] SrTxEmpty = 11'h040;
  localparam logic [10:0] SrAld     = 11'h020;
  localparam logic [10:0] SrSsd     = 11'h010;
  localparam logic [10:0] SrBbusy   = 11'h008;
  localparam logic [10:0] SrUbusy   = 11'h004;
  localparam logic [10:0] SrNack    = 11'h002;
  localparam logic [10:0] SrRxRead  = 11'h001;
  localparam logic [10:0] SrW1c     = 11'h7F0;

  localparam logic [31:0] BusMonValue = 32'h0000_0003;

  // one register access with the target's responses
  typedef struct packed {
    logic [7:0]  target_read_byte;
    logic        target_data_ack;
    logic        target_addr_ack;
    logic        target_present;
    logic [31:0] write_data;
    logic [1:0]  access_size;
    logic [4:0]  reg_offset;
    logic        opcode;
  } i2cmu_req_t;

  // result of one access
  typedef struct packed {
    logic        bus_stop;
    logic [7:0]  bus_byte_out;
    logic [1:0]  bus_command;
    logic        irq_level;
    logic        access_error;
    logic [31:0] read_data;
  } i2cmu_rsp_t;

  // interrupt line from status and per-source enables
  function automatic logic irq_eval(logic [15:0] ctl, logic [10:0] st);
    logic p;
    p = ((ctl & CrAldIe)  != '0 && (st & SrAld)     != '0) ||
        ((ctl & CrSsdIe)  != '0 && (st & SrSsd)     != '0) ||
        ((ctl & CrBerrIe) != '0 && (st & SrBerr)    != '0) ||
        ((ctl & CrRxfIe)  != '0 && (st & SrRxFull)  != '0) ||
        ((ctl & CrTxeIe)  != '0 && (st & SrTxEmpty) != '0);
    return p;
  endfunction

endpackage

### src/i2cmu_core.sv
// ----------------------------------------------------------------------------
// i2cmu_core
// register state and single-pass access logic of the i2c master unit
// ----------------------------------------------------------------------------
module i2cmu_core import i2cmu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,     // commit this access to the state
  input  i2cmu_req_t req_i,
  output i2cmu_rsp_t rsp_o
);

  logic [15:0] ctrl_q, ctrl_d;
  logic [10:0] stat_q, stat_d;
  logic [6:0]  sar_q, sar_d;
  logic [7:0]  dbuf_q, dbuf_d;
  logic [2:0]  mbcr_q, mbcr_d;
  logic        sel_q, sel_d;
  logic        dir_q, dir_d;
  logic        irq_q, irq_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
      stat_q <= SrTxEmpty;
      sar_q  <= '0;
      dbuf_q <= '0;
      mbcr_q <= '0;
      sel_q  <= 1'b0;
      dir_q  <= 1'b0;
      irq_q  <= 1'b0;
    end else if (en_i) begin
      ctrl_q <= ctrl_d;
      stat_q <= stat_d;
      sar_q  <= sar_d;
      dbuf_q <= dbuf_d;
      mbcr_q <= mbcr_d;
      sel_q  <= sel_d;
      dir_q  <= dir_d;
      irq_q  <= irq_d;
    end
  end

  always_comb begin
    i2cmu_reg_e  rsel;
    logic [31:0] lane;
    logic [31:0] cur;
    logic [31:0] wv;
    logic [15:0] ctl;
    logic        err;
    logic        pres;
    logic [1:0]  cmd;
    logic [7:0]  obyte;
    logic        ostop;

    rsel   = i2cmu_reg_e'(req_i.reg_offset[4:2]);
    pres   = req_i.target_present;
    ctrl_d = ctrl_q;
    stat_d = stat_q;
    sar_d  = sar_q;
    dbuf_d = dbuf_q;
    mbcr_d = mbcr_q;
    sel_d  = sel_q;
    dir_d  = dir_q;
    irq_d  = irq_q;
    cmd    = CmdNone;
    obyte  = '0;
    ostop  = 1'b0;
    err    = 1'b0;

    case (i2cmu_size_e'(req_i.access_size))
      SizeByte: lane = 32'h0000_00FF << {req_i.reg_offset[1:0], 3'b000};
      SizeHalf: lane = 32'h0000_FFFF << {req_i.reg_offset[1], 4'b0000};
      default:  lane = 32'hFFFF_FFFF;
    endcase

    case (rsel)
      RegControl: cur = {16'h0000, ctrl_q};
      RegStatus:  cur = {21'h0, stat_q};
      RegSlvAddr: cur = {25'h0, sar_q};
      RegDataBuf: cur = {24'h0, dbuf_q};
      RegBusMon:  cur = BusMonValue;
      RegBusCtrl: cur = {29'h0, mbcr_q};
      default: begin
        cur = '0;
        err = 1'b1;
      end
    endcase

    wv  = (cur & ~lane) | (req_i.write_data & lane);
    ctl = wv[15:0];

    if (!err && req_i.opcode == OpWrite) begin
      case (rsel)
        RegControl: begin
          if ((ctl & CrReset) != '0) begin
            // unit reset
            ctrl_d = '0;
            stat_d = SrTxEmpty;
            sar_d  = '0;
            dbuf_d = '0;
            mbcr_d = '0;
            sel_d  = 1'b0;
            dir_d  = 1'b0;
            ostop  = pres;
            irq_d  = 1'b0;
          end else begin
            ctrl_d = ctl & ~CrTbyte;
            if ((ctl & CrAbort) != '0 && (ctl & CrTbyte) == '0) begin
              sel_d  = 1'b0;
              dir_d  = 1'b0;
              ostop  = pres;
              stat_d = (stat_q & ~(SrBbusy | SrUbusy)) | SrTxEmpty;
            end else begin
              if ((ctl & CrTbyte) != '0) begin
                stat_d = stat_q & ~(SrRxFull | SrTxEmpty | SrNack | SrBerr |
                                    SrBbusy | SrUbusy);
                if ((ctl & CrStart) != '0) begin
                  // start with address byte
                  dir_d  = dbuf_q[0];
                  stat_d = (stat_d & ~(SrRxFull | SrNack | SrRxRead)) | SrTxEmpty;
                  if (dbuf_q[0]) stat_d = stat_d | SrRxRead;
                  if (pres) begin
                    cmd   = CmdAddr;
                    obyte = dbuf_q;
                  end
                  if (pres && req_i.target_addr_ack) begin
                    sel_d = 1'b1;
                  end else begin
                    sel_d  = 1'b0;
                    dir_d  = 1'b0;
                    stat_d = stat_d | SrNack;
                  end
                end else if (sel_q && dir_q && pres) begin
                  cmd    = CmdRead;
                  dbuf_d = req_i.target_read_byte;
                  stat_d = stat_d | SrRxFull | SrRxRead;
                  if (!req_i.target_data_ack) stat_d = stat_d | SrNack;
                end else if (sel_q && pres) begin
                  cmd    = CmdWrite;
                  obyte  = dbuf_q;
                  stat_d = stat_d | SrTxEmpty;
                  if (!req_i.target_data_ack) stat_d = stat_d | SrNack;
                end else begin
                  stat_d = stat_d | SrTxEmpty | SrNack;
                end
              end
              if ((ctl & CrStop) != '0) begin
                sel_d  = 1'b0;
                dir_d  = 1'b0;
                ostop  = pres;
                stat_d = stat_d & ~(SrBbusy | SrUbusy);
              end
            end
            irq_d = irq_eval(ctrl_d, stat_d);
          end
        end
        RegStatus: begin
          // write one to clear
          stat_d = stat_q & ~(wv[10:0] & SrW1c);
          irq_d  = irq_eval(ctrl_q, stat_d);
        end
        RegSlvAddr: sar_d  = wv[6:0];
        RegDataBuf: dbuf_d = wv[7:0];
        RegBusCtrl: mbcr_d = wv[2:0];
        default:    err    = 1'b1;
      endcase
    end

    rsp_o.read_data    = (!err && req_i.opcode == OpRead) ? (cur & lane) : '0;
    rsp_o.access_error = err;
    rsp_o.irq_level    = irq_d;
    rsp_o.bus_command  = cmd;
    rsp_o.bus_byte_out = obyte;
    rsp_o.bus_stop     = ostop;
  end

endmodule

### src/i2c_master_unit_registers_top.sv
// ----------------------------------------------------------------------------
// i2c_master_unit_registers_top
// register model of an interrupt-driven i2c master, one access per transaction
// ----------------------------------------------------------------------------
// each slave-side transaction carries one register access (read or write,
// offset, size, lane-positioned data) plus the attached target's responses
// to any bus action that access starts. each access yields exactly one
// master-side transaction with the read data, error flag, irq line and the
// bus command, byte and stop the access issued.
// the input register captures the access, then the access logic updates the
// register state and fills the result register once the result slot is free.
// one access is taken every cycle, limited only by the result register draining.
// while the receiver stalls the result register holds and the input register
// keeps one more access, after which s_axis_tready drops.
// reset clears both stages and puts all registers to their reset values:
// status reads tx empty only, everything else zero, irq low.
// ----------------------------------------------------------------------------
module i2c_master_unit_registers_top import i2cmu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // opcode[0], reg_offset[5:1], access_size[7:6], write_data[39:8],
  // target_present[40], target_addr_ack[41], target_data_ack[42],
  // target_read_byte[50:43], zero fill[55:51]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_data[31:0], access_error[32], irq_level[33], bus_command[35:34],
  // bus_byte_out[43:36], bus_stop[44], zero fill[47:45]
  output logic [OutDataW-1:0] m_axis_tdata
);

  logic       in_vld_q;
  i2cmu_req_t in_req_q;
  logic       out_vld_q;
  i2cmu_rsp_t out_rsp_q;
  i2cmu_rsp_t rsp;
  logic       advance;

  // the access in the input register moves on when the result slot is free or draining
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req_q <= i2cmu_req_t'(s_axis_tdata[50:0]);
    end
  end

  i2cmu_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .req_i  (in_req_q),
    .rsp_o  (rsp)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rsp_q <= rsp;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {3'b000, out_rsp_q};

endmodule
